@@ src/pbo_pkg.sv @@
// ----------------------------------------------------------------------------
// pbo_pkg
// shared types, constants and helpers for the polyline bisector offset block
// ----------------------------------------------------------------------------
`default_nettype none
package pbo_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 4096;
	localparam int unsigned IDX_W            = 12;
	localparam logic [IDX_W-1:0] IDX_MAX     = '1;
	localparam logic [16:0] U_ONE            = 17'd65536;

	typedef logic signed [31:0] coord_t;
	typedef coord_t [2:0] vert_t;
	typedef logic signed [17:0] ucomp_t;
	typedef ucomp_t [2:0] udir_t;

	// one result to be formed by the emit unit
	typedef struct packed {
		vert_t            v;
		udir_t            u;
		logic [IDX_W-1:0] index;
		logic             last;
	} emit_req_t;

	function automatic logic [IDX_W-1:0] sat_idx(input logic [31:0] i);
		logic [IDX_W-1:0] r;
		r = (i < 32'(IDX_MAX)) ? i[IDX_W-1:0] : IDX_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/pbo_dir.sv @@
// ----------------------------------------------------------------------------
// pbo_dir
// unit bisector of (2a - b - c): bit-serial normalize, root and quotients
// ----------------------------------------------------------------------------
`default_nettype none
module pbo_dir (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire pbo_pkg::vert_t a,
	input  wire pbo_pkg::vert_t b,
	input  wire pbo_pkg::vert_t c,
	output pbo_pkg::udir_t     u,
	output logic               done,
	output logic               busy
);
	import pbo_pkg::*;

	typedef enum logic [2:0] {D_IDLE, D_NORM, D_SQ, D_SQRT, D_DIV} dstate_t;

	dstate_t          state_q;
	logic [2:0]       neg_q;
	logic [33:0]      m_q [3];
	logic [63:0]      acc_q;
	logic [63:0]      r_q;
	logic [63:0]      bit_q;
	logic [1:0]       k_q;
	logic [4:0]       n_q;
	logic [47:0]      num_q [3];
	logic [31:0]      rem_q [3];
	logic [16:0]      quo_q [3];

	logic signed [34:0] bis [3];
	logic [33:0]        mag [3];
	logic               all_zero;
	logic               need_rsh;
	logic               need_lsh;
	logic [61:0]        sq;
	logic [63:0]        trial;
	logic [31:0]        len;

	always_comb begin
		all_zero = 1'b1;
		need_rsh = 1'b0;
		need_lsh = 1'b1;
		for (int k = 0; k < 3; k++) begin
			bis[k] = $signed({{2{a[k][31]}}, a[k], 1'b0}) - $signed({{3{b[k][31]}}, b[k]})
				- $signed({{3{c[k][31]}}, c[k]});
			mag[k] = bis[k][34] ? 34'(35'sd0 - bis[k]) : bis[k][33:0];
			if (mag[k] != '0) all_zero = 1'b0;
			if (m_q[k][33:31] != '0) need_rsh = 1'b1;
			if (m_q[k][30]) need_lsh = 1'b0;
		end
		sq    = m_q[k_q][30:0] * m_q[k_q][30:0];
		trial = r_q + bit_q;
		len   = r_q[31:0];
	end

	assign busy = (state_q != D_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done    <= 1'b0;
			u       <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (go) begin
						for (int k = 0; k < 3; k++) begin
							m_q[k]   <= mag[k];
							neg_q[k] <= bis[k][34];
						end
						if (all_zero) begin
							u    <= '0;
							done <= 1'b1;
						end else begin
							state_q <= D_NORM;
						end
					end
				end
				D_NORM: begin
					// largest magnitude moves until its top bit sits at bit 30
					if (need_rsh) begin
						for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
					end else if (need_lsh) begin
						for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
					end else begin
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= D_SQ;
					end
				end
				D_SQ: begin
					acc_q <= acc_q + 64'(sq);
					if (k_q == 2'd2) begin
						r_q     <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= D_SQRT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				D_SQRT: begin
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						r_q   <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						n_q     <= '0;
						state_q <= D_DIV;
					end
				end
				D_DIV: begin
					if (n_q == 5'd0) begin
						// quotient fits 17 bits, so the upper numerator bits preload the remainder
						for (int k = 0; k < 3; k++) begin
							logic [47:0] nm;
							nm = {m_q[k][30:0], 16'd0} + 48'(len >> 1);
							rem_q[k] <= {1'b0, nm[47:17]};
							num_q[k] <= {nm[16:0], 31'd0};
							quo_q[k] <= '0;
						end
						n_q <= 5'd1;
					end else begin
						for (int k = 0; k < 3; k++) begin
							logic [32:0] t;
							t = {rem_q[k], num_q[k][47]};
							num_q[k] <= num_q[k] << 1;
							if (t >= {1'b0, len}) begin
								rem_q[k] <= 32'(t - {1'b0, len});
								quo_q[k] <= {quo_q[k][15:0], 1'b1};
							end else begin
								rem_q[k] <= t[31:0];
								quo_q[k] <= {quo_q[k][15:0], 1'b0};
							end
						end
						n_q <= n_q + 5'd1;
						if (n_q == 5'd17) state_q <= D_IDLE;
					end
					if (n_q == 5'd17) begin
						done <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
			if (state_q == D_DIV && n_q == 5'd17) begin
				for (int k = 0; k < 3; k++) begin
					logic [16:0] q;
					logic [32:0] t;
					t = {rem_q[k], num_q[k][47]};
					q = {quo_q[k][15:0], (t >= {1'b0, len})};
					if (q > U_ONE) q = U_ONE;
					u[k] <= neg_q[k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/pbo_emit.sv @@
// ----------------------------------------------------------------------------
// pbo_emit
// forms one offset result an axis at a time and holds it until transferred
// ----------------------------------------------------------------------------
`default_nettype none
module pbo_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire pbo_pkg::emit_req_t  req,
	input  wire logic signed [31:0]  offset_d,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       out_x,
	output logic signed [31:0]       out_y,
	output logic signed [31:0]       out_z,
	output logic [pbo_pkg::IDX_W-1:0] out_index,
	output logic                     out_last,
	output logic                     done,
	output logic                     busy
);
	import pbo_pkg::*;

	typedef enum logic [1:0] {E_IDLE, E_MUL, E_ADD, E_HOLD} estate_t;

	estate_t         state_q;
	emit_req_t       req_q;
	logic [1:0]      k_q;
	logic [48:0]     prod_q;
	logic            neg_q;
	coord_t          res_q [3];

	logic [31:0]        dm;
	logic [16:0]        um;
	logic [33:0]        t;
	logic signed [34:0] r;
	coord_t             rs;

	always_comb begin
		dm = offset_d[31] ? 32'(33'd0 - 33'(offset_d)) : offset_d;
		um = req_q.u[k_q][17] ? 17'(18'sd0 - req_q.u[k_q]) : req_q.u[k_q][16:0];
		t  = 34'((50'(prod_q) + 50'd32768) >> 16);
		r  = $signed({{3{req_q.v[k_q][31]}}, req_q.v[k_q]})
			+ (neg_q ? -$signed({1'b0, t}) : $signed({1'b0, t}));
		if (r > 35'sd2147483647) rs = 32'sh7fffffff;
		else if (r < -35'sd2147483648) rs = 32'sh80000000;
		else rs = r[31:0];
	end

	assign busy      = (state_q != E_IDLE);
	assign out_valid = (state_q == E_HOLD);
	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign out_index = req_q.index;
	assign out_last  = req_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (go) begin
						req_q   <= req;
						k_q     <= '0;
						state_q <= E_MUL;
					end
				end
				E_MUL: begin
					prod_q  <= 49'(dm) * 49'(um);
					neg_q   <= offset_d[31] ^ req_q.u[k_q][17];
					state_q <= E_ADD;
				end
				E_ADD: begin
					res_q[k_q] <= rs;
					if (k_q == 2'd2) begin
						state_q <= E_HOLD;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= E_MUL;
					end
				end
				E_HOLD: begin
					if (!out_stall) begin
						done    <= 1'b1;
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/polyline_bisector_offset.sv @@
// ----------------------------------------------------------------------------
// polyline_bisector_offset
// offsets polyline vertices along their normalized bisectors
// ----------------------------------------------------------------------------
// One vertex is taken at a time; in_stall stays high until every result that
// vertex causes has been transferred. The first two vertices produce no result.
// Every later vertex runs the bisector unit through its normalize, squaring,
// root and quotient steps, and then the emit unit, which holds each result
// through any output stall. The final vertex adds the start and end results
// (and a second bisector pass for a closed polyline). The user writes
// offset_distance through cfg_wr_en and cfg_wr_data only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module polyline_bisector_offset #(
	parameter int unsigned MAX_VERTICES = pbo_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [31:0]             cfg_wr_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [31:0]      vert_x,
	input  wire logic signed [31:0]      vert_y,
	input  wire logic signed [31:0]      vert_z,
	input  wire logic                    vert_last,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [31:0]           out_x,
	output logic signed [31:0]           out_y,
	output logic signed [31:0]           out_z,
	output logic [pbo_pkg::IDX_W-1:0]    out_index,
	output logic                         out_last
);
	import pbo_pkg::*;

	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MID_DIR, ST_MID_EMIT, ST_END, ST_END_DIR, ST_START_EMIT, ST_STOP_EMIT
	} state_t;

	state_t           state_q;
	logic signed [31:0] dist_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	vert_t            prior_q, older_q, first_q, second_q;
	vert_t            cur_q, ctr_q, old_q;
	udir_t            sdir_q, edir_q, udir_q;
	logic             last_q;
	logic             closed_q;
	logic             dir_go_q;
	logic             em_go_q;
	emit_req_t        em_req_q;

	vert_t  in_v;
	vert_t  dir_a, dir_b, dir_c;
	udir_t  dir_u;
	logic   dir_done, dir_busy;
	logic   em_done, em_busy;
	logic   accept;
	logic   closed;

	assign in_v     = {vert_z, vert_y, vert_x};
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// closed: at least four vertices and the last one lands back on the first
	assign closed   = (idx_q >= CW'(3)) && (first_q == cur_q);

	// mid-polyline bisector uses the captured window, the closing one the ends
	assign dir_a = (state_q == ST_MID_DIR) ? ctr_q : first_q;
	assign dir_b = (state_q == ST_MID_DIR) ? old_q : second_q;
	assign dir_c = (state_q == ST_MID_DIR) ? cur_q : ctr_q;

	pbo_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dir_go_q),
		.a      (dir_a),
		.b      (dir_b),
		.c      (dir_c),
		.u      (dir_u),
		.done   (dir_done),
		.busy   (dir_busy)
	);

	pbo_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (em_go_q),
		.req       (em_req_q),
		.offset_d  (dist_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_index (out_index),
		.out_last  (out_last),
		.done      (em_done),
		.busy      (em_busy)
	);

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (cfg_wr_en) begin
			dist_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			prior_q  <= '0;
			older_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			sdir_q   <= '0;
			edir_q   <= '0;
			dir_go_q <= 1'b0;
			em_go_q  <= 1'b0;
		end else begin
			dir_go_q <= 1'b0;
			em_go_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q  <= in_v;
						last_q <= vert_last;
						idx_q  <= cnt_q;
						ctr_q  <= prior_q;
						old_q  <= older_q;
						if (cnt_q == '0) begin
							first_q <= in_v;
							sdir_q  <= '0;
							edir_q  <= '0;
						end
						if (cnt_q == CW'(1)) second_q <= in_v;
						if (!vert_last) begin
							older_q <= prior_q;
							prior_q <= in_v;
							if (cnt_q < CW'(MAX_VERTICES)) cnt_q <= cnt_q + CW'(1);
						end
						if (cnt_q >= CW'(2)) begin
							dir_go_q <= 1'b1;
							state_q  <= ST_MID_DIR;
						end else if (vert_last) begin
							state_q <= ST_END;
						end
					end
				end
				ST_MID_DIR: begin
					if (dir_done) begin
						edir_q <= dir_u;
						if (idx_q == CW'(2)) sdir_q <= dir_u;
						em_req_q <= '{v: ctr_q, u: dir_u,
							index: sat_idx(32'(idx_q - CW'(1))), last: 1'b0};
						em_go_q  <= 1'b1;
						state_q  <= ST_MID_EMIT;
					end
				end
				ST_MID_EMIT: begin
					if (em_done) state_q <= last_q ? ST_END : ST_IDLE;
				end
				ST_END: begin
					closed_q <= closed;
					if (closed) begin
						dir_go_q <= 1'b1;
						state_q  <= ST_END_DIR;
					end else begin
						em_req_q <= '{v: first_q, u: sdir_q, index: '0, last: 1'b0};
						em_go_q  <= 1'b1;
						state_q  <= ST_START_EMIT;
					end
				end
				ST_END_DIR: begin
					if (dir_done) begin
						udir_q   <= dir_u;
						em_req_q <= '{v: first_q, u: dir_u, index: '0, last: 1'b0};
						em_go_q  <= 1'b1;
						state_q  <= ST_START_EMIT;
					end
				end
				ST_START_EMIT: begin
					if (em_done) begin
						em_req_q <= '{v: closed_q ? first_q : cur_q,
							u: closed_q ? udir_q : edir_q,
							index: sat_idx(32'(idx_q)), last: 1'b1};
						em_go_q  <= 1'b1;
						state_q  <= ST_STOP_EMIT;
					end
				end
				ST_STOP_EMIT: begin
					if (em_done) begin
						// polyline finished, window back to reset
						cnt_q    <= '0;
						prior_q  <= '0;
						older_q  <= '0;
						first_q  <= '0;
						second_q <= '0;
						sdir_q   <= '0;
						edir_q   <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no new vertex is taken while a result waits
	a_no_accept_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("vertex accepted while a result is pending");

	// the two arithmetic units never run at once
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(dir_busy && em_busy))
		else $error("bisector and emit units busy together");

	// vertex count stays within its bound
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond bound");

endmodule
`default_nettype wire

@@ tb/pbo_checker.sv @@
// ----------------------------------------------------------------------------
// pbo_checker
// watches the vertex and result channels, predicts the offset vertices and
// compares every result transfer against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbo_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [31:0]          cfg_wr_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic signed [31:0]   vert_x,
	input  wire logic signed [31:0]   vert_y,
	input  wire logic signed [31:0]   vert_z,
	input  wire logic                 vert_last,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic signed [31:0]   out_x,
	input  wire logic signed [31:0]   out_y,
	input  wire logic signed [31:0]   out_z,
	input  wire logic [11:0]          out_index,
	input  wire logic                 out_last,
	output int                        fail_count,
	output int                        pending
);
	import pbo_pkg::*;

	localparam int unsigned VCOUNT_MAX = 4096;

	typedef struct {
		coord_t           x;
		coord_t           y;
		coord_t           z;
		logic [IDX_W-1:0] index;
		logic             last;
	} offset_pt_t;

	offset_pt_t  offset_q[$];
	int          n_waiting;
	int          n_fail;
	coord_t      distance;
	vert_t       win_prior, win_older, poly_first, poly_second;
	udir_t       dir_start, dir_end;
	int unsigned n_seen;

	assign pending    = n_waiting;
	assign fail_count = n_fail;

	function automatic logic [63:0] int_sqrt(input logic [63:0] s);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector of (2a - b - c) in q1.16
	function automatic udir_t bisector_dir(input vert_t a, input vert_t b, input vert_t c);
		longint      bis [3];
		logic [63:0] m [3];
		logic [63:0] mx, s, len, q;
		int          msb;
		udir_t       u;
		mx = 0;
		s = 0;
		msb = 0;
		u = '0;
		for (int k = 0; k < 3; k++) begin
			bis[k] = 2 * longint'(a[k]) - longint'(b[k]) - longint'(c[k]);
			m[k] = (bis[k] < 0) ? 64'(-bis[k]) : 64'(bis[k]);
			if (m[k] > mx) mx = m[k];
		end
		if (mx == 0) return u;
		while ((mx >> msb) > 1) msb++;
		for (int k = 0; k < 3; k++) begin
			if (msb > 30) m[k] = m[k] >> (msb - 30);
			else m[k] = m[k] << (30 - msb);
			s = s + m[k] * m[k];
		end
		len = int_sqrt(s);
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * 64'd65536 + len / 2) / len;
			if (q > 64'd65536) q = 64'd65536;
			u[k] = (bis[k] < 0) ? -ucomp_t'(q) : ucomp_t'(q);
		end
		return u;
	endfunction

	function automatic offset_pt_t offset_point(input vert_t v, input udir_t u,
			input int unsigned index, input logic lastf);
		offset_pt_t  p;
		coord_t      c [3];
		logic [63:0] dm, um, t;
		longint      r;
		logic        neg;
		dm = (distance < 0) ? 64'(-longint'(distance)) : 64'(distance);
		for (int k = 0; k < 3; k++) begin
			um = (u[k] < 0) ? 64'(-longint'(u[k])) : 64'(u[k]);
			t = (dm * um + 64'd32768) >> 16;
			neg = (distance < 0) != (u[k] < 0);
			r = longint'(v[k]) + (neg ? -longint'(t) : longint'(t));
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			c[k] = coord_t'(r);
		end
		p.x = c[0];
		p.y = c[1];
		p.z = c[2];
		p.index = (index < 4095) ? index[IDX_W-1:0] : IDX_MAX;
		p.last = lastf;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vert_t       cur;
		udir_t       u;
		offset_pt_t  exp_pt;
		logic        closed;
		int unsigned idx;
		if (!arst_n) begin
			distance    = 0;
			win_prior   = '0;
			win_older   = '0;
			poly_first  = '0;
			poly_second = '0;
			dir_start   = '0;
			dir_end     = '0;
			n_seen      = 0;
			n_waiting   = 0;
			n_fail      = 0;
			offset_q.delete();
		end else begin
			if (cfg_wr_en) distance = coord_t'(cfg_wr_data);

			// vertex transfer: predict first so a same-cycle result still finds it
			if (in_valid && !in_stall) begin
				cur = {vert_z, vert_y, vert_x};
				idx = n_seen;
				if (idx == 0) begin
					poly_first = cur;
					dir_start  = '0;
					dir_end    = '0;
				end else if (idx == 1) begin
					poly_second = cur;
				end else begin
					u = bisector_dir(win_prior, win_older, cur);
					if (idx == 2) dir_start = u;
					dir_end = u;
					offset_q.push_back(offset_point(win_prior, u, idx - 1, 1'b0));
				end
				if (vert_last) begin
					closed = (idx >= 3) && (poly_first == cur);
					if (closed) begin
						u = bisector_dir(poly_first, poly_second, win_prior);
						offset_q.push_back(offset_point(poly_first, u, 0, 1'b0));
						offset_q.push_back(offset_point(poly_first, u, idx, 1'b1));
					end else begin
						offset_q.push_back(offset_point(poly_first, dir_start, 0, 1'b0));
						offset_q.push_back(offset_point(cur, dir_end, idx, 1'b1));
					end
					win_prior   = '0;
					win_older   = '0;
					poly_first  = '0;
					poly_second = '0;
					dir_start   = '0;
					dir_end     = '0;
					n_seen      = 0;
				end else begin
					win_older = win_prior;
					win_prior = cur;
					if (n_seen < VCOUNT_MAX) n_seen++;
				end
			end

			if (out_valid && !out_stall) begin
				if (offset_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("mismatch: unexpected result x=%0d y=%0d z=%0d idx=%0d last=%0d",
							out_x, out_y, out_z, out_index, out_last);
				end else begin
					exp_pt = offset_q.pop_front();
					if (out_x !== exp_pt.x || out_y !== exp_pt.y || out_z !== exp_pt.z ||
							out_index !== exp_pt.index || out_last !== exp_pt.last) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: exp %0d %0d %0d idx=%0d last=%0d got %0d %0d %0d idx=%0d last=%0d",
								exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.index, exp_pt.last,
								out_x, out_y, out_z, out_index, out_last);
					end
				end
			end
			n_waiting = offset_q.size();
		end
	end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives polylines and offset settings into the bisector offset block; the
// checker beside it predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import pbo_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 150;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [31:0]  cfg_wr_data = '0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	coord_t       vert_x = '0;
	coord_t       vert_y = '0;
	coord_t       vert_z = '0;
	logic         vert_last = 1'b0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	coord_t       out_x, out_y, out_z;
	logic [11:0]  out_index;
	logic         out_last;
	int           fail_count;
	int           pending;

	// sender burst shaping
	int burst_left = 0;
	// receiver stall probability in percent, switched now and then
	int stall_pct = 0;
	int idle_cycles = 0;
	int vertices_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	polyline_bisector_offset uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .vert_last(vert_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_index(out_index), .out_last(out_last)
	);

	pbo_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .vert_last(vert_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_index(out_index), .out_last(out_last),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: stall on its own random pattern, stretches without stalls too
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always begin
		repeat ($urandom_range(50, 400)) @(negedge clk);
		case ($urandom_range(0, 3))
			0: stall_pct = 0;
			1: stall_pct = 25;
			2: stall_pct = 60;
			default: stall_pct = 90;
		endcase
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// one vertex transfer, valid held within a burst and dropped only for gaps
	task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
			input logic lastf);
		@(negedge clk);
		vert_x    <= x;
		vert_y    <= y;
		vert_z    <= z;
		vert_last <= lastf;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		vertices_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	endtask

	// offset register is only written once the block has gone idle
	task automatic set_distance(input logic [31:0] d);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic coord_t pick_coord(input int cmode);
		case (cmode)
			0: pick_coord = coord_t'($urandom);
			1: pick_coord = coord_t'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: pick_coord = 32'sh7FFF_FFFF;
					1: pick_coord = 32'sh8000_0000;
					2: pick_coord = 0;
					3: pick_coord = 1;
					default: pick_coord = -1;
				endcase
			end
		endcase
	endfunction

	function automatic coord_t pick_distance();
		case ($urandom_range(0, 5))
			0: pick_distance = 32'sh7FFF_FFFF;
			1: pick_distance = 32'sh8000_0000;
			2: pick_distance = 0;
			3: pick_distance = 32'sh0001_0000;
			4: pick_distance = coord_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: pick_distance = coord_t'($urandom);
		endcase
	endfunction

	// one polyline of n vertices; closed ones repeat the first as the last
	task automatic send_polyline(input int n, input bit closed, input int cmode);
		vert_t first, p1, p2, v;
		for (int i = 0; i < n; i++) begin
			if (closed && i == n - 1) begin
				v = first;
			end else if (cmode == 1 && i >= 2 && $urandom_range(0, 3) == 0) begin
				// evenly spaced collinear point: zero bisector at p1
				for (int k = 0; k < 3; k++) v[k] = 2 * p1[k] - p2[k];
			end else begin
				for (int k = 0; k < 3; k++) v[k] = pick_coord(cmode);
			end
			if (i == 0) first = v;
			p2 = p1;
			p1 = v;
			send_vertex(v[0], v[1], v[2], i == n - 1);
		end
	endtask

	initial begin
		int n;
		bit closed;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: single vertex at reset distance
		send_vertex(32'sd5, -32'sd7, 32'sd9, 1'b1);
		set_distance(32'h0001_0000);
		// two vertices, no interior
		send_vertex(32'sh0001_0000, 0, 0, 1'b0);
		send_vertex(32'sh0003_0000, 32'sh0002_0000, 0, 1'b1);
		// three evenly spaced collinear vertices: zero bisector
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 1'b1);
		// three vertices with first equal to last: too short to be closed
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(32'sh0004_0000, 0, 0, 1'b0);
		send_vertex(0, 0, 0, 1'b1);
		// closed square
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(32'sh0004_0000, 0, 0, 1'b0);
		send_vertex(32'sh0004_0000, 32'sh0004_0000, 0, 1'b0);
		send_vertex(0, 32'sh0004_0000, 0, 1'b0);
		send_vertex(0, 0, 0, 1'b1);
		// coordinate extremes with largest distance: saturation both ways
		set_distance(32'h7FFF_FFFF);
		send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		set_distance(32'h8000_0000);
		send_polyline(4, 1'b0, 2);

		// random polylines, distance changed between phases
		while (vertices_sent < 262) begin
			if ($urandom_range(0, 5) == 0) set_distance(pick_distance());
			n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 9);
			closed = (n >= 4) && ($urandom_range(0, 2) == 0);
			send_polyline(n, closed, $urandom_range(0, 9) < 2 ? 2 : $urandom_range(0, 1));
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
src/pbo_pkg.sv
src/pbo_dir.sv
src/pbo_emit.sv
src/polyline_bisector_offset.sv
tb/pbo_checker.sv
tb/testbench.sv
